>>> hdl/dfd_pkg.sv
// shared types and constants of the detection frame deframer
`timescale 1ns / 1ps

package dfd_pkg;

  localparam int unsigned SYNC_LEN    = 8;
  localparam int unsigned BOX_WORDS   = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] START_BYTE0 = 8'hFF;
  localparam logic [7:0] START_BYTE1 = 8'hD8;

  localparam logic [15:0] TIMEOUT_RESET     = 16'd5000;
  localparam logic [15:0] BOX_LIMIT_RESET   = 16'd255;
  localparam logic [23:0] IMAGE_LIMIT_RESET = 24'd32768;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LIMIT = 2'd2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BOX    = 2'd1,
    KIND_IMAGE  = 2'd2,
    KIND_ERROR  = 2'd3
  } dfd_kind_e;

  typedef enum logic [2:0] {
    ERR_TIMEOUT     = 3'd0,
    ERR_BOXES       = 3'd1,
    ERR_IMAGE_LARGE = 3'd2,
    ERR_BAD_START   = 3'd3,
    ERR_IMAGE_SMALL = 3'd4
  } dfd_err_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } dfd_in_t;

  typedef struct packed {
    dfd_kind_e   kind;
    logic [63:0] frame_number;
    logic [15:0] box_count;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_right;
    logic [15:0] box_bottom;
    logic [15:0] box_class;
    logic [31:0] score_bits;
    logic [7:0]  image_byte;
    logic        last;
    logic [2:0]  error_code;
  } dfd_out_t;

  // pair: the entry stands for two items, a leading start byte and then res
  typedef struct packed {
    logic     pair;
    dfd_out_t res;
  } dfd_entry_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] box_limit;
    logic [23:0] image_limit;
  } dfd_cfg_t;

  function automatic logic [7:0] sync_byte(logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'hA5;
      3'd1: b = 8'h5A;
      3'd2: b = 8'hAA;
      3'd3: b = 8'h55;
      3'd4: b = 8'hAB;
      3'd5: b = 8'hCD;
      3'd6: b = 8'hEF;
      default: b = 8'hFE;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/dfd_parser.sv
// front end: parses bytes and ticks and queues result entries
`timescale 1ns / 1ps

module dfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfd_pkg::dfd_cfg_t   cfg_i,
  input  logic                in_valid_i,
  input  dfd_pkg::dfd_in_t    in_data_i,
  input  logic                space_i,
  output logic                in_ready_o,
  output logic                push_valid_o,
  output dfd_pkg::dfd_entry_t push_entry_o
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_FRAME  = 3'd1;
  localparam logic [2:0] PH_COUNT  = 3'd2;
  localparam logic [2:0] PH_BOX    = 3'd3;
  localparam logic [2:0] PH_SIZE   = 3'd4;
  localparam logic [2:0] PH_START0 = 3'd5;
  localparam logic [2:0] PH_START1 = 3'd6;
  localparam logic [2:0] PH_IMAGE  = 3'd7;

  localparam logic [2:0]  SYNC_LAST  = 3'(dfd_pkg::SYNC_LEN - 1);
  localparam logic [2:0]  SCORE_FLD  = 3'(dfd_pkg::BOX_WORDS);
  localparam logic [16:0] TICK_MAX   = '1;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  sync_q, sync_d;
  logic [16:0] tick_q, tick_d;
  logic [2:0]  pos_q, pos_d;
  logic [2:0]  field_q, field_d;
  logic [15:0] boxes_q, boxes_d;
  logic [15:0] box_idx_q, box_idx_d;
  logic [63:0] asm_q, asm_d;
  logic [15:0] words_q [dfd_pkg::BOX_WORDS];
  logic [15:0] words_d [dfd_pkg::BOX_WORDS];
  logic [23:0] remain_q, remain_d;
  logic [7:0]  first_q, first_d;

  logic        accept;
  logic        go_hunt;
  logic [7:0]  b;
  logic [16:0] tick_inc;
  logic [15:0] count16;
  logic [15:0] box_next;
  logic [31:0] size32;
  logic [23:0] rem1;
  logic [23:0] rem2;

  function automatic dfd_pkg::dfd_entry_t err_entry(dfd_pkg::dfd_err_e code);
    dfd_pkg::dfd_entry_t e;
    e                = '0;
    e.res.kind       = dfd_pkg::KIND_ERROR;
    e.res.error_code = code;
    return e;
  endfunction

  function automatic dfd_pkg::dfd_entry_t img_entry(logic [7:0] data, logic last, logic pair);
    dfd_pkg::dfd_entry_t e;
    e                = '0;
    e.pair           = pair;
    e.res.kind       = dfd_pkg::KIND_IMAGE;
    e.res.image_byte = data;
    e.res.last       = last;
    return e;
  endfunction

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;
  assign b          = in_data_i.rx_byte;
  assign tick_inc   = tick_q + 17'(tick_q != TICK_MAX);
  assign count16    = {b, boxes_q[7:0]};
  assign box_next   = box_idx_q + 16'd1;
  assign size32     = {b, asm_q[23:0]};
  assign rem1       = remain_q - 24'd1;
  assign rem2       = remain_q - 24'd2;

  always_comb begin
    phase_d      = phase_q;
    sync_d       = sync_q;
    tick_d       = tick_q;
    pos_d        = pos_q;
    field_d      = field_q;
    boxes_d      = boxes_q;
    box_idx_d    = box_idx_q;
    asm_d        = asm_q;
    words_d      = words_q;
    remain_d     = remain_q;
    first_d      = first_q;
    go_hunt      = 1'b0;
    push_valid_o = 1'b0;
    push_entry_o = '0;
    if (accept) begin
      if (in_data_i.req_type) begin
        // ticks only count while hunting
        if (phase_q == PH_HUNT) begin
          tick_d = tick_inc;
          if (tick_inc > {1'b0, cfg_i.timeout_ticks}) begin
            push_valid_o = 1'b1;
            push_entry_o = err_entry(dfd_pkg::ERR_TIMEOUT);
            go_hunt      = 1'b1;
          end
        end
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            if (b == dfd_pkg::sync_byte(sync_q)) begin
              if (sync_q == SYNC_LAST) begin
                phase_d = PH_FRAME;
                pos_d   = '0;
                sync_d  = '0;
              end else begin
                sync_d = sync_q + 3'd1;
              end
            end else begin
              sync_d = '0;
            end
          end
          PH_FRAME: begin
            asm_d[{pos_q, 3'b000} +: 8] = b;
            pos_d = pos_q + 3'd1;
            if (pos_q == 3'd7) begin
              phase_d = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (pos_q == 3'd0) begin
              boxes_d = {8'h00, b};
              pos_d   = 3'd1;
            end else begin
              boxes_d      = count16;
              push_valid_o = 1'b1;
              if (count16 >= cfg_i.box_limit) begin
                push_entry_o = err_entry(dfd_pkg::ERR_BOXES);
                go_hunt      = 1'b1;
              end else begin
                push_entry_o.res.kind         = dfd_pkg::KIND_HEADER;
                push_entry_o.res.frame_number = asm_q;
                push_entry_o.res.box_count    = count16;
                box_idx_d = '0;
                field_d   = '0;
                pos_d     = '0;
                phase_d   = (count16 == 16'd0) ? PH_SIZE : PH_BOX;
              end
            end
          end
          PH_BOX: begin
            asm_d[{pos_q, 3'b000} +: 8] = b;
            if (field_q != SCORE_FLD) begin
              if (pos_q == 3'd0) begin
                pos_d = 3'd1;
              end else begin
                words_d[field_q] = {b, asm_q[7:0]};
                field_d          = field_q + 3'd1;
                pos_d            = '0;
              end
            end else if (pos_q != 3'd3) begin
              pos_d = pos_q + 3'd1;
            end else begin
              push_valid_o                = 1'b1;
              push_entry_o.res.kind       = dfd_pkg::KIND_BOX;
              push_entry_o.res.box_left   = words_q[0];
              push_entry_o.res.box_top    = words_q[1];
              push_entry_o.res.box_right  = words_q[2];
              push_entry_o.res.box_bottom = words_q[3];
              push_entry_o.res.box_class  = words_q[4];
              push_entry_o.res.score_bits = {b, asm_q[23:0]};
              field_d   = '0;
              pos_d     = '0;
              box_idx_d = box_next;
              phase_d   = (box_next >= boxes_q) ? PH_SIZE : PH_BOX;
            end
          end
          PH_SIZE: begin
            asm_d[{pos_q, 3'b000} +: 8] = b;
            if (pos_q != 3'd3) begin
              pos_d = pos_q + 3'd1;
            end else if (size32 > {8'h00, cfg_i.image_limit}) begin
              push_valid_o = 1'b1;
              push_entry_o = err_entry(dfd_pkg::ERR_IMAGE_LARGE);
              go_hunt      = 1'b1;
            end else if (size32 < 32'd2) begin
              push_valid_o = 1'b1;
              push_entry_o = err_entry(dfd_pkg::ERR_IMAGE_SMALL);
              go_hunt      = 1'b1;
            end else begin
              remain_d = size32[23:0];
              pos_d    = '0;
              phase_d  = PH_START0;
            end
          end
          PH_START0: begin
            first_d = b;
            phase_d = PH_START1;
          end
          PH_START1: begin
            push_valid_o = 1'b1;
            if (first_q != dfd_pkg::START_BYTE0 || b != dfd_pkg::START_BYTE1) begin
              push_entry_o = err_entry(dfd_pkg::ERR_BAD_START);
              go_hunt      = 1'b1;
            end else begin
              // one entry carries both start bytes
              push_entry_o = img_entry(dfd_pkg::START_BYTE1, rem2 == 24'd0, 1'b1);
              remain_d     = rem2;
              go_hunt      = (rem2 == 24'd0);
              phase_d      = PH_IMAGE;
            end
          end
          PH_IMAGE: begin
            push_valid_o = 1'b1;
            push_entry_o = img_entry(b, rem1 == 24'd0, 1'b0);
            remain_d     = rem1;
            go_hunt      = (rem1 == 24'd0);
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
      if (go_hunt) begin
        phase_d = PH_HUNT;
        sync_d  = '0;
        tick_d  = '0;
        pos_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      sync_q    <= '0;
      tick_q    <= '0;
      pos_q     <= '0;
      field_q   <= '0;
      boxes_q   <= '0;
      box_idx_q <= '0;
    end else begin
      phase_q   <= phase_d;
      sync_q    <= sync_d;
      tick_q    <= tick_d;
      pos_q     <= pos_d;
      field_q   <= field_d;
      boxes_q   <= boxes_d;
      box_idx_q <= box_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q    <= asm_d;
    words_q  <= words_d;
    remain_q <= remain_d;
    first_q  <= first_d;
  end

endmodule

>>> hdl/dfd_queue.sv
// short queue of result entries between parser and emitter
`timescale 1ns / 1ps

module dfd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  dfd_pkg::dfd_entry_t push_entry_i,
  output logic                space_o,
  output logic                head_valid_o,
  output dfd_pkg::dfd_entry_t head_o,
  input  logic                pop_i
);

  localparam int unsigned DEPTH = dfd_pkg::QUEUE_DEPTH;
  localparam logic [dfd_pkg::QPTR_W-1:0] PTR_LAST = dfd_pkg::QPTR_W'(DEPTH - 1);
  localparam logic [dfd_pkg::QCNT_W-1:0] CNT_FULL = dfd_pkg::QCNT_W'(DEPTH);

  dfd_pkg::dfd_entry_t mem_q [DEPTH];
  logic [dfd_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [dfd_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [dfd_pkg::QCNT_W-1:0] count_q, count_d;
  logic do_pop;

  assign space_o      = (count_q != CNT_FULL);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_valid_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + dfd_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + dfd_pkg::QPTR_W'(1);
    end
    unique case ({push_valid_i, do_pop})
      2'b10:   count_d = count_q + dfd_pkg::QCNT_W'(1);
      2'b01:   count_d = count_q - dfd_pkg::QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> hdl/dfd_emitter.sv
// back end: output register, splits start-byte pairs into two items
`timescale 1ns / 1ps

module dfd_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  dfd_pkg::dfd_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dfd_pkg::dfd_out_t   out_data_o
);

  logic              valid_q, valid_d;
  logic              half_q, half_d;
  dfd_pkg::dfd_out_t data_q, data_d;
  logic              load;

  assign load        = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    data_d  = data_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.pair && !half_q) begin
          // leading start byte first, entry stays at the head
          data_d            = head_i.res;
          data_d.image_byte = dfd_pkg::START_BYTE0;
          data_d.last       = 1'b0;
          half_d            = 1'b1;
        end else begin
          data_d = head_i.res;
          half_d = 1'b0;
          pop_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

>>> hdl/detection_frame_deframer.sv
// Path: results of an accepted item are written into the queue, then into the output register at out_valid_o.
// Throughput: one item per cycle while the queue has space, set by the parser and output register;
// a correct start-byte pair stays at the queue head for both start bytes and can stall the input.
// Reset (rst_ni low, asynchronous): parser back to sync hunt, queue and output empty,
// configuration registers back to timeout 5000, box limit 255, image limit 32768.
`timescale 1ns / 1ps

module detection_frame_deframer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dfd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [dfd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  dfd_pkg::dfd_in_t                     in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output dfd_pkg::dfd_out_t                    out_data_o
);

  dfd_pkg::dfd_cfg_t   cfg_q;
  logic                space;
  logic                push_valid;
  dfd_pkg::dfd_entry_t push_entry;
  logic                head_valid;
  dfd_pkg::dfd_entry_t head;
  logic                pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= dfd_pkg::TIMEOUT_RESET;
      cfg_q.box_limit     <= dfd_pkg::BOX_LIMIT_RESET;
      cfg_q.image_limit   <= dfd_pkg::IMAGE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfd_pkg::CFG_TIMEOUT:     cfg_q.timeout_ticks <= cfg_wdata_i[15:0];
        dfd_pkg::CFG_BOX_LIMIT:   cfg_q.box_limit     <= cfg_wdata_i[15:0];
        dfd_pkg::CFG_IMAGE_LIMIT: cfg_q.image_limit   <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  dfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .space_i      (space),
    .in_ready_o   (in_ready_o),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry)
  );

  dfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .space_o      (space),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  dfd_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> hdl/dfd_checker.sv
// port-level checks of the deframer, bound to the top level
`timescale 1ns / 1ps

module dfd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dfd_pkg::dfd_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == dfd_pkg::KIND_ERROR |->
      out_data_o.frame_number == '0 && out_data_o.image_byte == '0 &&
      out_data_o.last == 1'b0 && out_data_o.error_code <= 3'd4)
    else $error("error item carries foreign fields or bad code");

  a_code_only_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != dfd_pkg::KIND_ERROR |->
      out_data_o.error_code == '0)
    else $error("error code outside an error item");

  a_last_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.kind == dfd_pkg::KIND_IMAGE)
    else $error("last set on a non-image item");

endmodule

bind detection_frame_deframer dfd_checker u_dfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/tb_detection_frame_deframer.sv
// self-checking testbench of the detection frame deframer: predicted results against the block
`timescale 1ns / 1ps

module tb_detection_frame_deframer;

  localparam logic [63:0] SYNC_WORD = 64'hA55A_AA55_ABCD_EFFE;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned NO_CUT = 32'h4000_0000;
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef enum logic [2:0] {
    ST_HUNT, ST_FRAME, ST_COUNT, ST_BOX, ST_SIZE, ST_START0, ST_START1, ST_IMAGE
  } parse_st_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [dfd_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [dfd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  dfd_pkg::dfd_in_t               in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  dfd_pkg::dfd_out_t              out_data;

  detection_frame_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // pending input items and predicted parser results
  dfd_pkg::dfd_in_t  rx_items_q[$];
  dfd_pkg::dfd_out_t parsed_q[$];

  // register copies
  logic [15:0] lim_timeout = dfd_pkg::TIMEOUT_RESET;
  logic [15:0] lim_boxes   = dfd_pkg::BOX_LIMIT_RESET;
  logic [23:0] lim_image   = dfd_pkg::IMAGE_LIMIT_RESET;

  // parser state
  parse_st_e   st = ST_HUNT;
  int unsigned sync_pos = 0;
  logic [16:0] tick_cnt = '0;
  int unsigned byte_pos = 0;
  logic [63:0] acc = '0;
  logic [15:0] n_boxes = '0;
  logic [15:0] box_no = '0;
  logic [15:0] box_word [dfd_pkg::BOX_WORDS];
  int unsigned word_no = 0;
  logic [23:0] img_left = '0;
  logic [7:0]  start0 = '0;

  int unsigned n_fail = 0;
  int unsigned n_pushed = 0;
  int unsigned n_ticks = 0;
  int unsigned n_settings = 1;
  int unsigned n_hdr = 0, n_box = 0, n_img = 0, n_err = 0;
  int unsigned cycles = 0;
  int unsigned cut_left = NO_CUT;
  int unsigned tick_odds = 0;

  function automatic void to_hunt();
    st = ST_HUNT;
    sync_pos = 0;
    tick_cnt = '0;
    byte_pos = 0;
    acc = '0;
  endfunction

  function automatic void next_field(parse_st_e s);
    st = s;
    byte_pos = 0;
    acc = '0;
  endfunction

  function automatic void post_error(dfd_pkg::dfd_err_e code);
    dfd_pkg::dfd_out_t r;
    r = '0;
    r.kind = dfd_pkg::KIND_ERROR;
    r.error_code = code;
    parsed_q.push_back(r);
    to_hunt();
  endfunction

  function automatic void post_image(logic [7:0] b, logic fin);
    dfd_pkg::dfd_out_t r;
    r = '0;
    r.kind = dfd_pkg::KIND_IMAGE;
    r.image_byte = b;
    r.last = fin;
    parsed_q.push_back(r);
  endfunction

  function automatic void deframe(dfd_pkg::dfd_in_t it);
    dfd_pkg::dfd_out_t r;
    logic [7:0]        b;
    int unsigned       len;
    r = '0;
    b = it.rx_byte;
    if (it.req_type) begin
      // ticks only count while hunting
      if (st == ST_HUNT) begin
        if (tick_cnt != 17'h1FFFF) tick_cnt = tick_cnt + 17'd1;
        if (tick_cnt > {1'b0, lim_timeout}) post_error(dfd_pkg::ERR_TIMEOUT);
      end
    end else begin
      case (st)
        ST_HUNT: begin
          if (SYNC_WORD[8 * (7 - sync_pos) +: 8] == b) begin
            sync_pos++;
            if (sync_pos >= 8) next_field(ST_FRAME);
          end else begin
            sync_pos = 0;
          end
        end
        ST_FRAME: begin
          acc = acc | (64'(b) << (8 * byte_pos));
          if (byte_pos >= 7) begin
            st = ST_COUNT;
            byte_pos = 0;
            n_boxes = '0;
          end else begin
            byte_pos++;
          end
        end
        ST_COUNT: begin
          if (byte_pos == 0) begin
            n_boxes = {8'h00, b};
            byte_pos = 1;
          end else begin
            n_boxes[15:8] = b;
            if (n_boxes >= lim_boxes) begin
              post_error(dfd_pkg::ERR_BOXES);
            end else begin
              r.kind = dfd_pkg::KIND_HEADER;
              r.frame_number = acc;
              r.box_count = n_boxes;
              parsed_q.push_back(r);
              box_no = '0;
              word_no = 0;
              next_field(n_boxes == 16'd0 ? ST_SIZE : ST_BOX);
            end
          end
        end
        ST_BOX: begin
          acc = acc | (64'(b) << (8 * byte_pos));
          len = (word_no < dfd_pkg::BOX_WORDS) ? 2 : 4;
          if (byte_pos + 1 < len) begin
            byte_pos++;
          end else if (word_no < dfd_pkg::BOX_WORDS) begin
            box_word[word_no] = acc[15:0];
            word_no++;
            next_field(ST_BOX);
          end else begin
            r.kind = dfd_pkg::KIND_BOX;
            r.box_left = box_word[0];
            r.box_top = box_word[1];
            r.box_right = box_word[2];
            r.box_bottom = box_word[3];
            r.box_class = box_word[4];
            r.score_bits = acc[31:0];
            parsed_q.push_back(r);
            word_no = 0;
            box_no = box_no + 16'd1;
            next_field(box_no >= n_boxes ? ST_SIZE : ST_BOX);
          end
        end
        ST_SIZE: begin
          acc = acc | (64'(b) << (8 * byte_pos));
          if (byte_pos < 3) begin
            byte_pos++;
          end else if (acc > 64'(lim_image)) begin
            post_error(dfd_pkg::ERR_IMAGE_LARGE);
          end else if (acc < 64'd2) begin
            post_error(dfd_pkg::ERR_IMAGE_SMALL);
          end else begin
            img_left = acc[23:0];
            next_field(ST_START0);
          end
        end
        ST_START0: begin
          start0 = b;
          st = ST_START1;
        end
        ST_START1: begin
          if (start0 != dfd_pkg::START_BYTE0 || b != dfd_pkg::START_BYTE1) begin
            post_error(dfd_pkg::ERR_BAD_START);
          end else begin
            img_left = img_left - 24'd2;
            post_image(dfd_pkg::START_BYTE0, 1'b0);
            post_image(dfd_pkg::START_BYTE1, img_left == 24'd0);
            if (img_left == 24'd0) to_hunt();
            else st = ST_IMAGE;
          end
        end
        default: begin
          img_left = img_left - 24'd1;
          post_image(b, img_left == 24'd0);
          if (img_left == 24'd0) to_hunt();
        end
      endcase
    end
  endfunction

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 9))
      5, 6, 7: return $urandom_range(1, 3);
      8:       return $urandom_range(1, 12);
      9:       return $urandom_range(20, 40);
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) deframe(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_items_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= rx_items_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = pick_gap();
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: random stall modes, each redrawn when its random run length is used up
  int unsigned rdy_mode = 0;
  int unsigned mode_left = 0;
  int unsigned rdy_phase = 0;

  function automatic void check_field(string nm, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, want, got);
      n_fail++;
    end
  endfunction

  function automatic void check_result(dfd_pkg::dfd_out_t got);
    dfd_pkg::dfd_out_t want;
    if (parsed_q.size() == 0) begin
      $display("%0t: item with no prediction, kind %0d", $time, got.kind);
      n_fail++;
    end else begin
      want = parsed_q.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("frame_number", want.frame_number, got.frame_number);
      check_field("box_count", want.box_count, got.box_count);
      check_field("box_left", want.box_left, got.box_left);
      check_field("box_top", want.box_top, got.box_top);
      check_field("box_right", want.box_right, got.box_right);
      check_field("box_bottom", want.box_bottom, got.box_bottom);
      check_field("box_class", want.box_class, got.box_class);
      check_field("score_bits", want.score_bits, got.score_bits);
      check_field("image_byte", want.image_byte, got.image_byte);
      check_field("last", want.last, got.last);
      check_field("error_code", want.error_code, got.error_code);
      case (want.kind)
        dfd_pkg::KIND_HEADER: n_hdr++;
        dfd_pkg::KIND_BOX:    n_box++;
        dfd_pkg::KIND_IMAGE:  n_img++;
        default:              n_err++;
      endcase
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (mode_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      rdy_phase++;
      case (rdy_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (rdy_phase % 3 == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL detection_frame_deframer");
      $finish;
    end
  end

  // stimulus helpers
  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_item(logic t, logic [7:0] b);
    dfd_pkg::dfd_in_t it;
    it.req_type = t;
    it.rx_byte = b;
    rx_items_q.push_back(it);
    n_pushed++;
    if (t) n_ticks++;
  endtask

  task automatic push_byte(logic [7:0] b);
    if (cut_left == 0) return;
    cut_left--;
    if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) push_item(1'b1, 8'($urandom));
    push_item(1'b0, b);
  endtask

  task automatic push_le(logic [63:0] v, int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(v[8 * i +: 8]);
  endtask

  task automatic push_frame(logic [63:0] fn, logic [15:0] nb, int unsigned boxes,
                            logic [31:0] size, logic [7:0] s0, logic [7:0] s1,
                            int unsigned img);
    for (int unsigned i = 0; i < 8; i++) push_byte(SYNC_WORD[8 * (7 - i) +: 8]);
    push_le(fn, 8);
    push_le(64'(nb), 2);
    repeat (boxes * 14) push_byte(rnd_byte());
    push_le(64'(size), 4);
    push_byte(s0);
    push_byte(s1);
    repeat (img) push_byte(rnd_byte());
  endtask

  task automatic push_random_frame(bit trunc_ok);
    logic [63:0] fn;
    logic [15:0] nb;
    logic [31:0] size;
    logic [7:0]  s0, s1;
    int unsigned sel;
    cut_left = NO_CUT;
    case ($urandom_range(0, 7))
      0:       fn = '0;
      1:       fn = '1;
      default: fn = {$urandom, $urandom};
    endcase
    nb = 16'($urandom_range(0, 3));
    if (lim_boxes != 0 && lim_boxes <= 3) nb = 16'($urandom_range(0, lim_boxes - 1));
    size = (lim_image < 24'd14) ? $urandom_range(2, 32'(lim_image)) : $urandom_range(2, 14);
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      push_frame(fn, nb, nb, size, dfd_pkg::START_BYTE0, dfd_pkg::START_BYTE1, size - 2);
    end else if (sel < 63) begin
      // box count at or above the limit
      nb = (lim_boxes > 16'hFFFC) ? 16'hFFFF : lim_boxes + 16'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) nb = 16'hFFFF;
      push_frame(fn, nb, 0, 0, 8'h00, 8'h00, 0);
    end else if (sel < 70) begin
      case ($urandom_range(0, 2))
        0:       size = 32'(lim_image) + $urandom_range(1, 4);
        1:       size = 32'hFFFF_FFFF;
        default: size = 32'h0100_0000;
      endcase
      push_frame(fn, nb, nb, size, dfd_pkg::START_BYTE0, dfd_pkg::START_BYTE1, 0);
    end else if (sel < 76) begin
      push_frame(fn, nb, nb, $urandom_range(0, 1), dfd_pkg::START_BYTE0,
                 dfd_pkg::START_BYTE1, 0);
    end else if (sel < 84) begin
      case ($urandom_range(0, 2))
        0: begin
          s0 = 8'hFE;
          s1 = dfd_pkg::START_BYTE1;
        end
        1: begin
          s0 = dfd_pkg::START_BYTE0;
          s1 = 8'hD9;
        end
        default: begin
          s0 = rnd_byte();
          s1 = rnd_byte();
          if (s0 == dfd_pkg::START_BYTE0 && s1 == dfd_pkg::START_BYTE1) s1 = 8'h00;
        end
      endcase
      push_frame(fn, nb, nb, size, s0, s1, 0);
    end else if (sel < 90 && trunc_ok) begin
      // frame that may be cut short, so the next sync word can land in its fields
      cut_left = $urandom_range(9, 40);
      push_frame(fn, nb, nb, size, dfd_pkg::START_BYTE0, dfd_pkg::START_BYTE1, size - 2);
    end else begin
      // partial sync then noise
      sel = $urandom_range(0, 7);
      for (int unsigned i = 0; i < sel; i++) push_byte(SYNC_WORD[8 * (7 - i) +: 8]);
      repeat ($urandom_range(1, 10)) push_byte(rnd_byte());
    end
    cut_left = NO_CUT;
  endtask

  task automatic wait_idle();
    do begin
      while (rx_items_q.size() != 0 || in_valid || parsed_q.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end while (rx_items_q.size() != 0 || in_valid || parsed_q.size() != 0);
  endtask

  // drain, then feed zero bytes until the parser is back to hunting
  task automatic settle_hunt();
    wait_idle();
    while (st != ST_HUNT) begin
      repeat (16) push_item(1'b0, 8'h00);
      wait_idle();
    end
  endtask

  task automatic write_cfg(logic [15:0] t, logic [15:0] bl, logic [23:0] il);
    cfg_we <= 1'b1;
    cfg_idx <= dfd_pkg::CFG_TIMEOUT;
    cfg_wdata <= dfd_pkg::CFG_DATA_W'(t);
    @(posedge clk_i);
    cfg_idx <= dfd_pkg::CFG_BOX_LIMIT;
    cfg_wdata <= dfd_pkg::CFG_DATA_W'(bl);
    @(posedge clk_i);
    cfg_idx <= dfd_pkg::CFG_IMAGE_LIMIT;
    cfg_wdata <= dfd_pkg::CFG_DATA_W'(il);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    lim_timeout = t;
    lim_boxes = bl;
    lim_image = il;
    n_settings++;
  endtask

  task automatic run_random(int unsigned budget, bit trunc_ok);
    int unsigned start;
    start = n_pushed;
    while (n_pushed - start < budget) push_random_frame(trunc_ok);
    settle_hunt();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tick while hunting, sync mismatch on a repeated first byte, smallest frame
    push_item(1'b1, 8'h3C);
    push_byte(8'hA5);
    push_byte(8'h5A);
    push_byte(8'hA5);
    push_frame('1, 16'd0, 0, 32'd2, dfd_pkg::START_BYTE0, dfd_pkg::START_BYTE1, 0);
    settle_hunt();

    // reset settings, one longer image
    tick_odds = 24;
    push_frame({$urandom, $urandom}, 16'd1, 1, 32'd100, dfd_pkg::START_BYTE0,
               dfd_pkg::START_BYTE1, 98);
    run_random(130, 1'b1);

    // lowest limits: every tick while hunting times out
    write_cfg(16'd0, 16'd1, 24'd2);
    tick_odds = 40;
    run_random(60, 1'b1);

    // highest limits, then a run of ticks well under the timeout
    write_cfg(16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
    tick_odds = 0;
    run_random(90, 1'b0);
    repeat (60) push_item(1'b1, 8'($urandom));
    settle_hunt();

    // tight random limits with frequent ticks
    write_cfg(16'($urandom_range(2, 20)), 16'($urandom_range(2, 5)),
              24'($urandom_range(8, 40)));
    tick_odds = 6;
    run_random(70, 1'b1);

    // back to the reset values
    write_cfg(dfd_pkg::TIMEOUT_RESET, dfd_pkg::BOX_LIMIT_RESET, dfd_pkg::IMAGE_LIMIT_RESET);
    tick_odds = 16;
    run_random(80, 1'b1);
    wait_idle();

    $display("covered %0d items (%0d ticks) over %0d register settings in %0d cycles",
             n_pushed, n_ticks, n_settings, cycles);
    $display("checked %0d headers, %0d boxes, %0d image bytes, %0d errors, %0d mismatches",
             n_hdr, n_box, n_img, n_err, n_fail);
    if (n_fail == 0 && parsed_q.size() == 0) begin
      $display("PASS detection_frame_deframer");
    end else begin
      $display("FAIL detection_frame_deframer");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/dfd_pkg.sv
hdl/dfd_parser.sv
hdl/dfd_queue.sv
hdl/dfd_emitter.sv
hdl/detection_frame_deframer.sv
hdl/dfd_checker.sv
tb/tb_detection_frame_deframer.sv
